[src/fmbq_pkg.sv]
// ============================================================================
// fmbq_pkg
// Shared types, codes and elaboration helpers for the front/middle/back queue.
// ============================================================================
package fmbq_pkg;

  localparam int FMBQ_CAPACITY  = 1024;
  localparam int FMBQ_WORD_BITS = 32;
  localparam int TREE_FANIN     = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } fmbq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } fmbq_status_t;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic signed [31:0] push_value;
  } fmbq_in_t;

  typedef struct packed {
    fmbq_status_t       status;
    logic signed [31:0] pop_value;
    logic        [10:0] occupancy;
  } fmbq_out_t;

  // per-cell shift command
  typedef struct packed {
    logic ins;
    logic rem;
  } fmbq_cell_ctrl_t;

  // result fields known at accept time, carried beside the readback tree
  typedef struct packed {
    fmbq_status_t status;
    logic         neg_one;
    logic [10:0]  occupancy;
  } fmbq_side_t;

  // register levels of the readback OR tree
  function automatic int tree_levels(input int n);
    int l;
    int span;
    l    = 0;
    span = 1;
    while (span < n) begin
      span = span * TREE_FANIN;
      l++;
    end
    return (l < 1) ? 1 : l;
  endfunction

  function automatic int tree_groups(input int n, input int k);
    return TREE_FANIN ** (tree_levels(n) - k);
  endfunction

  function automatic int tree_offset(input int n, input int k);
    int ofs;
    ofs = 0;
    for (int i = 0; i < k; i++) begin
      ofs = ofs + tree_groups(n, i);
    end
    return ofs;
  endfunction

endpackage

[src/fmbq_cell.sv]
// ============================================================================
// fmbq_cell
// One queue slot: holds, loads, or takes a neighbour's word on insert/remove.
// ============================================================================
module fmbq_cell #(
  parameter int W     = 32,
  parameter int IDX_W = 10,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  fmbq_pkg::fmbq_cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]          pos,
  input  logic [W-1:0]              new_word,
  input  logic [W-1:0]              left_word,
  input  logic [W-1:0]              right_word,
  output logic [W-1:0]              word,
  output logic [W-1:0]              sel_word
);
  import fmbq_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [W-1:0] word_r;
  logic [W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctrl.ins) begin
      if (MY_IDX > pos) begin
        word_nxt = left_word;
      end else if (MY_IDX == pos) begin
        word_nxt = new_word;
      end
    end else if (ctrl.rem) begin
      if (MY_IDX >= pos) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word     = word_r;
  assign sel_word = (ctrl.rem && (MY_IDX == pos)) ? word_r : '0;

endmodule

[src/fmbq_or_tree.sv]
// ============================================================================
// fmbq_or_tree
// Pipelined wide OR reduction; returns the one selected cell word.
// ============================================================================
module fmbq_or_tree #(
  parameter int W = 32,
  parameter int N = 1024
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] result
);
  import fmbq_pkg::*;

  localparam int LEVELS = tree_levels(N);
  localparam int NPAD   = TREE_FANIN ** LEVELS;
  localparam int TOTAL  = tree_offset(N, LEVELS + 1);

  wire [W-1:0] nodes [TOTAL];

  // level 0: leaves, padded with zeros
  for (genvar j = 0; j < NPAD; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign nodes[j] = leaf[j];
    end else begin : g_pad
      assign nodes[j] = '0;
    end
  end

  for (genvar k = 1; k <= LEVELS; k++) begin : g_lvl
    localparam int G    = tree_groups(N, k);
    localparam int OFS  = tree_offset(N, k);
    localparam int PREV = tree_offset(N, k - 1);
    for (genvar j = 0; j < G; j++) begin : g_grp
      logic [W-1:0] grp_or;
      logic [W-1:0] grp_r;
      always_comb begin
        grp_or = '0;
        for (int m = 0; m < TREE_FANIN; m++) begin
          grp_or = grp_or | nodes[PREV + j*TREE_FANIN + m];
        end
      end
      always_ff @(posedge clk) begin
        grp_r <= grp_or;
      end
      assign nodes[OFS + j] = grp_r;
    end
  end

  assign result = nodes[TOTAL-1];

endmodule

[src/front_middle_back_queue.sv]
// ============================================================================
// front_middle_back_queue
// Ordered word queue with push/pop at front, middle and back, held in a row
// of shifting cells.
// ============================================================================
// Throughput: one operation per cycle while in_ready is high; the cell row
//   updates its contents in the cycle an operation is accepted.
// Results: each passes the registered readback OR tree, then the result
//   buffer; in_ready falls while that buffer has no room for another beat.
// Reset: synchronous, active low; clears the word count, pipeline valids and
//   result buffer. Cell contents are left as they are.
module front_middle_back_queue #(
  parameter int CAPACITY  = fmbq_pkg::FMBQ_CAPACITY,
  parameter int WORD_BITS = fmbq_pkg::FMBQ_WORD_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fmbq_pkg::fmbq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fmbq_pkg::fmbq_out_t out_data
);
  import fmbq_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int LEVELS = tree_levels(CAPACITY);
  // result buffer: covers every beat in flight plus one being drained
  localparam int QD     = LEVELS + 2;
  localparam int QA_W   = $clog2(QD);
  localparam int QC_W   = $clog2(QD + 1);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // ---------------------------------------------------------------- decode
  logic             in_fire;
  logic             is_push;
  logic             is_pop;
  logic             q_full;
  logic             q_empty;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] pos_w;
  logic [IDX_W-1:0] pos;
  fmbq_cell_ctrl_t  ctrl;
  fmbq_side_t       side_in;
  logic [63:0]      push_wide;
  logic [WORD_BITS-1:0] push_word;

  assign in_fire = in_valid & in_ready;
  assign q_full  = (count_r >= CAP_CNT);
  assign q_empty = (count_r == '0);

  // position of the touched word; a full push-back never reaches the row
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos_w   = '0;
    unique case (fmbq_op_t'(in_data.opcode))
      OP_PUSH_FRONT: begin
        is_push = 1'b1;
      end
      OP_PUSH_MIDDLE: begin
        is_push = 1'b1;
        pos_w   = count_r >> 1;
      end
      OP_PUSH_BACK: begin
        is_push = 1'b1;
        pos_w   = count_r;
      end
      OP_POP_FRONT: begin
        is_pop = 1'b1;
      end
      OP_POP_MIDDLE: begin
        is_pop = 1'b1;
        pos_w  = (count_r - CNT_W'(1)) >> 1;
      end
      OP_POP_BACK: begin
        is_pop = 1'b1;
        pos_w  = count_r - CNT_W'(1);
      end
      default: begin
        // unused opcodes change nothing
      end
    endcase
  end

  assign pos      = pos_w[IDX_W-1:0];
  assign ctrl.ins = in_fire & is_push & ~q_full;
  assign ctrl.rem = in_fire & is_pop & ~q_empty;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    side_in.status  = ST_OK;
    side_in.neg_one = 1'b0;
    if (is_push && q_full) begin
      side_in.status = ST_FULL;
    end else if (is_pop && q_empty) begin
      side_in.status  = ST_EMPTY;
      side_in.neg_one = 1'b1;
    end
    side_in.occupancy = 11'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // pushes store the low WORD_BITS of the zero-extended beat
  assign push_wide = 64'(unsigned'(in_data.push_value));
  assign push_word = push_wide[WORD_BITS-1:0];

  // -------------------------------------------------------------- cell row
  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic [WORD_BITS-1:0] cell_sel  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = push_word;
    end else begin : g_left
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[i+1];
    end
    fmbq_cell #(
      .W     (WORD_BITS),
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .new_word   (push_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[i]),
      .sel_word   (cell_sel[i])
    );
  end

  // ------------------------------------------------------- popped readback
  // only the removed cell drives its word, so an OR gathers it
  logic [WORD_BITS-1:0] tree_out;

  fmbq_or_tree #(
    .W (WORD_BITS),
    .N (CAPACITY)
  ) u_tree (
    .clk    (clk),
    .leaf   (cell_sel),
    .result (tree_out)
  );

  // sideband follows the tree level by level
  logic [LEVELS-1:0] pv_valid_r;
  fmbq_side_t        side_r [LEVELS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_valid_r <= '0;
    end else begin
      pv_valid_r <= LEVELS'({pv_valid_r, in_fire});
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int s = 1; s < LEVELS; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  fmbq_out_t   res;
  logic [63:0] pop_ext;

  assign pop_ext = 64'($signed(tree_out));

  always_comb begin
    res.status    = side_r[LEVELS-1].status;
    res.occupancy = side_r[LEVELS-1].occupancy;
    res.pop_value = side_r[LEVELS-1].neg_one ? '1 : signed'(pop_ext[31:0]);
  end

  // --------------------------------------------------------- result buffer
  fmbq_out_t        rq_r [QD];
  logic [QA_W-1:0]  rq_wr_r;
  logic [QA_W-1:0]  rq_rd_r;
  logic [QC_W-1:0]  rq_cnt_r;
  logic             rq_push;
  logic             rq_pop;
  logic [QC_W:0]    pending;

  assign rq_push = pv_valid_r[LEVELS-1];
  assign rq_pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (rq_push) begin
        rq_wr_r <= (rq_wr_r == QA_W'(QD - 1)) ? '0 : rq_wr_r + QA_W'(1);
      end
      if (rq_pop) begin
        rq_rd_r <= (rq_rd_r == QA_W'(QD - 1)) ? '0 : rq_rd_r + QA_W'(1);
      end
      if (rq_push && !rq_pop) begin
        rq_cnt_r <= rq_cnt_r + QC_W'(1);
      end else if (!rq_push && rq_pop) begin
        rq_cnt_r <= rq_cnt_r - QC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wr_r] <= res;
    end
  end

  // room for every beat in flight keeps the buffer from overflowing
  assign pending   = (QC_W+1)'(rq_cnt_r) + (QC_W+1)'($countones(pv_valid_r));
  assign in_ready  = (pending < (QC_W+1)'(QD));
  assign out_valid = (rq_cnt_r != '0);
  assign out_data  = rq_r[rq_rd_r];

endmodule

[src/fmbq_checker.sv]
// ============================================================================
// fmbq_props
// Port-level checks of the queue's result beats, bound to the top level.
// ============================================================================
module fmbq_props #(
  parameter int CAPACITY = fmbq_pkg::FMBQ_CAPACITY
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input fmbq_pkg::fmbq_out_t out_data
);
  import fmbq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

  a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.pop_value == -32'sd1 && out_data.occupancy == 11'd0)
    else $error("empty pop beat malformed");

  a_full_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.pop_value == 32'sd0 && out_data.occupancy == 11'(CAPACITY))
    else $error("full push beat malformed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

endmodule

bind front_middle_back_queue fmbq_props #(.CAPACITY(CAPACITY)) u_fmbq_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/fmbq_checker.sv]
// ============================================================================
// fmbq_checker
// Passive watcher for the front/middle/back queue: keeps its own copy of the
// word sequence, predicts one result per accepted input beat and compares
// every accepted result beat, field by field, with the oldest prediction.
// ============================================================================
module fmbq_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fmbq_pkg::fmbq_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fmbq_pkg::fmbq_out_t out_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fmbq_pkg::*;

  localparam int CAP = FMBQ_CAPACITY;
  localparam int WB  = FMBQ_WORD_BITS;

  logic [WB-1:0] queue_words[$];     // front at index 0
  fmbq_out_t     expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic fmbq_out_t apply_queue_op(input fmbq_in_t beat);
    fmbq_out_t res;
    int        n;
    int        pos;
    n             = queue_words.size();
    pos           = 0;
    res.status    = ST_OK;
    res.pop_value = '0;
    case (beat.opcode)
      OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
        if (n >= CAP) begin
          res.status = ST_FULL;
        end else begin
          if (beat.opcode == OP_PUSH_MIDDLE) pos = n / 2;
          else if (beat.opcode == OP_PUSH_BACK) pos = n;
          queue_words.insert(pos, beat.push_value[WB-1:0]);
        end
      end
      OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
        if (n == 0) begin
          res.status    = ST_EMPTY;
          res.pop_value = -32'sd1;
        end else begin
          if (beat.opcode == OP_POP_MIDDLE) pos = (n - 1) / 2;
          else if (beat.opcode == OP_POP_BACK) pos = n - 1;
          res.pop_value = 32'(signed'(queue_words[pos]));
          queue_words.delete(pos);
        end
      end
      default: ;
    endcase
    res.occupancy = 11'(queue_words.size());
    return res;
  endfunction

  always @(posedge clk) begin
    fmbq_out_t want;
    if (!rst_n) begin
      queue_words.delete();
      expected_results.delete();
    end else begin
      // results first: a beat accepted now cannot answer an input of this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(out_data), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.pop_value !== want.pop_value)
            report_mismatch("pop_value", out_data.pop_value, want.pop_value);
          if (out_data.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_data.occupancy),
                            32'(want.occupancy));
        end
      end
      if (in_valid && in_ready)
        expected_results.insert(expected_results.size(), apply_queue_op(in_data));
    end
    pending = expected_results.size();
  end

endmodule

[dv/testbench.sv]
// ============================================================================
// testbench
// Stimulus and verdict for the front/middle/back queue: a directed opening,
// then random phases that fill the queue to capacity and drain it part way,
// with random idling on both channels and one long receiver hold-off.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fmbq_pkg::*;

  localparam int          CAP          = FMBQ_CAPACITY;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd6;   // no operation assigned
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam int          MIXED_BEATS  = 200;
  localparam int          FULL_EXTRA   = 30;     // beats offered once full
  localparam int          DRAIN_BEATS  = 250;
  localparam int          HOLD_AFTER   = 400;    // results before the hold-off
  localparam int          HOLD_CYCLES  = 250;
  localparam int          END_SLACK    = 16;     // extra wait once no result is pending

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  fmbq_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  fmbq_out_t out_data;
  int        fail_count;
  int        pending;

  int        depth;      // words held, tracked only to steer the phases
  bit        tx_steady;  // sender offers back to back while set
  bit        rx_steady;  // receiver ready without gaps while set, but for the hold-off
  int        rx_taken;

  front_middle_back_queue DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  fmbq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: ends the run with a failing status if no verdict came first.
  initial begin
    #400_000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender: draws an idle gap before each beat, then holds the beat until it
  // is taken. Only one nonblocking write of in_valid per time step.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic [2:0] op, input logic [31:0] val);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.opcode     <= op;
    in_data.push_value <= val;
    do @(posedge clk); while (!in_ready);
    // rough depth, only used to decide when a phase is done
    if (op <= OP_PUSH_BACK && depth < CAP) depth++;
    else if (op >= OP_POP_FRONT && op <= OP_POP_BACK && depth > 0) depth--;
  endtask

  // mostly uniform words, with the extremes mixed in now and then
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return 3'($urandom_range(OP_PUSH_FRONT, OP_PUSH_BACK));
  endfunction

  function automatic logic [2:0] pick_pop();
    return 3'($urandom_range(OP_POP_FRONT, OP_POP_BACK));
  endfunction

  // push_pct in percent; a small share of beats carry an unused opcode
  function automatic logic [2:0] pick_op(input int push_pct);
    if ($urandom_range(0, 31) == 0)
      return $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
    return ($urandom_range(0, 99) < push_pct) ? pick_push() : pick_pop();
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random gap per result, quiet stretches, and one long hold-off
  // while the sender keeps offering, so the block backs up to its input.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    out_ready = 1'b0;
    rx_steady = 1'b0;
    rx_taken  = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 3);
      if (rx_taken == HOLD_AFTER) gap = HOLD_CYCLES;
      repeat (gap) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      rx_taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    depth     = 0;
    tx_steady = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every pop on an empty queue, unused codes, word extremes,
    // each push, middle positions on odd and even counts, drain to empty.
    send_beat(OP_POP_FRONT, 32'h1234_5678);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_POP_BACK, 32'hffff_ffff);
    send_beat(OP_UNUSED_LO, 32'hdead_beef);
    send_beat(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_beat(OP_PUSH_BACK, 32'h8000_0000);
    send_beat(OP_PUSH_MIDDLE, 32'h0000_0000);
    send_beat(OP_PUSH_MIDDLE, 32'hffff_ffff);
    send_beat(OP_PUSH_FRONT, 32'h5555_5555);
    send_beat(OP_PUSH_BACK, 32'haaaa_aaaa);
    send_beat(OP_UNUSED_HI, 32'hffff_ffff);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_PUSH_MIDDLE, 32'h0000_0001);
    send_beat(OP_POP_FRONT, 32'h0);
    send_beat(OP_POP_BACK, 32'h0);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_POP_FRONT, 32'h0);
    send_beat(OP_POP_MIDDLE, 32'h0);
    send_beat(OP_POP_BACK, 32'h0);

    // mixed traffic around small depths, empty pops included
    repeat (MIXED_BEATS) send_beat(pick_op(50), pick_word());

    // fill to capacity, then keep offering mostly pushes, which are dropped while full
    while (depth < CAP) send_beat(pick_op(93), pick_word());
    repeat (FULL_EXTRA) send_beat(pick_op(85), pick_word());

    // drain part way with all positions in play
    repeat (DRAIN_BEATS) send_beat(pick_op(20), pick_word());

    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
